### rtl/kvi_pkg.sv
// Shared widths, codes and interface types of the keyframe vector interpolator.
package kvi_pkg;

    localparam int DATA_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int FRAC_W  = 16;
    localparam int BLEND_W = 17;
    localparam int PROD_W  = 51;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [BLEND_W-1:0] BLEND_ZERO = 17'h00000;
    localparam logic [BLEND_W-1:0] BLEND_ONE  = 17'h10000;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;
    localparam logic signed [PROD_W-1:0] MIX_HALF = 51'sd32768;

    typedef logic [2:0][DATA_W-1:0] vec_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] t0;
        logic [DATA_W-1:0] t1;
        logic [DATA_W-1:0] q;
    } blend_req_t;

    typedef struct packed {
        logic               done;
        logic [BLEND_W-1:0] factor;
    } blend_rsp_t;

    typedef struct packed {
        logic               start;
        logic [BLEND_W-1:0] factor;
        vec_t               a;
        vec_t               b;
    } mix_req_t;

    typedef struct packed {
        logic done;
        vec_t v;
    } mix_rsp_t;

endpackage

### rtl/keyframe_vector_interpolator_core.sv
// A key write leaves the block idle; a query holds the input while the block walks
// the key time memory, runs the 16-step blend divider (skipped when the factor is
// clamped, and with the walk when there is a single key) and the three-pass blend
// multiplier.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
// Reset sets the key count to one and empties the output; key memories hold junk.
module keyframe_vector_interpolator_core #(
    parameter int MAX_KEYS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [kvi_pkg::COUNT_W-1:0]           cfg_wdata,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic                                  func,
    input  logic [kvi_pkg::SLOT_W-1:0]            key_slot,
    input  logic [kvi_pkg::DATA_W-1:0]            key_time,
    input  logic signed [kvi_pkg::DATA_W-1:0]     key_x,
    input  logic signed [kvi_pkg::DATA_W-1:0]     key_y,
    input  logic signed [kvi_pkg::DATA_W-1:0]     key_z,
    input  logic [kvi_pkg::DATA_W-1:0]            query_time,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [kvi_pkg::DATA_W-1:0]     out_x,
    output logic signed [kvi_pkg::DATA_W-1:0]     out_y,
    output logic signed [kvi_pkg::DATA_W-1:0]     out_z,
    output logic [kvi_pkg::SLOT_W-1:0]            segment,
    output logic [kvi_pkg::BLEND_W-1:0]           blend
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int DW = kvi_pkg::DATA_W;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_T0_RD  = 13'b0000000000010,
        ST_T0_CAP = 13'b0000000000100,
        ST_S_RD   = 13'b0000000001000,
        ST_S_CMP  = 13'b0000000010000,
        ST_VA_RD  = 13'b0000000100000,
        ST_VA_CAP = 13'b0000001000000,
        ST_VB_RD  = 13'b0000010000000,
        ST_VB_CAP = 13'b0000100000000,
        ST_BLD    = 13'b0001000000000,
        ST_MIX_ST = 13'b0010000000000,
        ST_MIX_W  = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [kvi_pkg::COUNT_W-1:0]    count_reg;
    logic                           res_valid_reg, res_valid_next;

    logic [DW-1:0]                  q_reg, q_next;
    logic [AW-1:0]                  last_reg, last_next;
    logic                           single_reg, single_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [AW-1:0]                  seg_reg, seg_next;
    logic [DW-1:0]                  tprev_reg, tprev_next;
    logic [DW-1:0]                  t0_reg, t0_next;
    logic [DW-1:0]                  t1_reg, t1_next;
    kvi_pkg::vec_t                  a_reg, a_next;
    kvi_pkg::vec_t                  b_reg, b_next;
    logic [kvi_pkg::BLEND_W-1:0]    f_reg, f_next;
    kvi_pkg::vec_t                  outv_reg;
    logic [kvi_pkg::SLOT_W-1:0]     segment_reg;
    logic [kvi_pkg::BLEND_W-1:0]    blend_reg;

    logic                           req_accept;
    logic                           slot_ok;
    logic                           key_we;
    logic [AW-1:0]                  key_waddr;
    logic [31:0]                    n_eff;
    logic [AW-1:0]                  t_raddr;
    logic [AW-1:0]                  v_raddr;
    logic [DW-1:0]                  t_rdata;
    kvi_pkg::vec_t                  v_rdata;
    logic                           out_load;

    kvi_pkg::blend_req_t            blend_req;
    kvi_pkg::blend_rsp_t            blend_rsp;
    kvi_pkg::mix_req_t              mix_req;
    kvi_pkg::mix_rsp_t              mix_rsp;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_accept = req_valid && req_ready;
    assign slot_ok    = 32'(key_slot) < 32'(MAX_KEYS);
    assign key_we     = req_accept && (func == kvi_pkg::FUNC_WRITE) && slot_ok;
    assign key_waddr  = AW'(key_slot);
    assign out_load   = !res_valid_reg || res_ready;

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = 32'd1;
        end
        else if (32'(count_reg) > 32'(MAX_KEYS))
        begin
            n_eff = 32'(MAX_KEYS);
        end
        else
        begin
            n_eff = 32'(count_reg);
        end
    end

    assign t_raddr = (state_reg == ST_S_RD) ? AW'(idx_reg + 1'b1) : '0;
    assign v_raddr = (state_reg == ST_VB_RD) ? AW'(seg_reg + 1'b1) : seg_reg;

    kvi_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_time),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    kvi_ram #(
        .WIDTH (3 * DW),
        .DEPTH (MAX_KEYS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata ({key_z, key_y, key_x}),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    assign blend_req.start = (state_reg == ST_VB_CAP);
    assign blend_req.t0    = t0_reg;
    assign blend_req.t1    = t1_reg;
    assign blend_req.q     = q_reg;

    kvi_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .rsp   (blend_rsp)
    );

    assign mix_req.start  = (state_reg == ST_MIX_ST);
    assign mix_req.factor = f_reg;
    assign mix_req.a      = a_reg;
    assign mix_req.b      = b_reg;

    kvi_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mix_req),
        .rsp   (mix_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        last_next   = last_reg;
        single_next = single_reg;
        idx_next    = idx_reg;
        seg_next    = seg_reg;
        tprev_next  = tprev_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        f_next      = f_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (func == kvi_pkg::FUNC_QUERY))
                begin
                    q_next      = query_time;
                    single_next = (n_eff == 32'd1);
                    last_next   = AW'(n_eff - 32'd2);
                    idx_next    = '0;
                    seg_next    = '0;
                    state_next  = (n_eff == 32'd1) ? ST_VA_RD : ST_T0_RD;
                end
            end
            ST_T0_RD:
            begin
                state_next = ST_T0_CAP;
            end
            ST_T0_CAP:
            begin
                tprev_next = t_rdata;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                state_next = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                // The last segment is taken when no later key lies beyond the query.
                if (q_reg < t_rdata || idx_reg == last_reg)
                begin
                    seg_next   = idx_reg;
                    t0_next    = tprev_reg;
                    t1_next    = t_rdata;
                    state_next = ST_VA_RD;
                end
                else
                begin
                    tprev_next = t_rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_VA_RD:
            begin
                state_next = ST_VA_CAP;
            end
            ST_VA_CAP:
            begin
                a_next = v_rdata;
                if (single_reg)
                begin
                    f_next     = kvi_pkg::BLEND_ZERO;
                    state_next = ST_MIX_ST;
                end
                else
                begin
                    state_next = ST_VB_RD;
                end
            end
            ST_VB_RD:
            begin
                state_next = ST_VB_CAP;
            end
            ST_VB_CAP:
            begin
                b_next     = v_rdata;
                state_next = ST_BLD;
            end
            ST_BLD:
            begin
                if (blend_rsp.done)
                begin
                    f_next     = blend_rsp.factor;
                    state_next = ST_MIX_ST;
                end
            end
            ST_MIX_ST:
            begin
                state_next = ST_MIX_W;
            end
            ST_MIX_W:
            begin
                if (mix_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (state_reg == ST_OUT && out_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= kvi_pkg::COUNT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        last_reg   <= last_next;
        single_reg <= single_next;
        idx_reg    <= idx_next;
        seg_reg    <= seg_next;
        tprev_reg  <= tprev_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        f_reg      <= f_next;
        if (state_reg == ST_OUT && out_load)
        begin
            outv_reg    <= mix_rsp.v;
            segment_reg <= kvi_pkg::SLOT_W'(seg_reg);
            blend_reg   <= f_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_x     = outv_reg[0];
    assign out_y     = outv_reg[1];
    assign out_z     = outv_reg[2];
    assign segment   = segment_reg;
    assign blend     = blend_reg;

endmodule

### rtl/kvi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/kvi_blend.sv
// Blend factor unit: range checks and a 16-step restoring divider.
module kvi_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  kvi_pkg::blend_req_t req,
    output kvi_pkg::blend_rsp_t rsp
);

    localparam int CNT_W = $clog2(kvi_pkg::FRAC_W + 1);
    localparam int DW    = kvi_pkg::DATA_W;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PREP = 4'b0010,
        B_CHK  = 4'b0100,
        B_DIV  = 4'b1000
    } bstate_t;

    bstate_t                      state_reg, state_next;
    logic signed [DW:0]           mid_reg, mid_next;
    logic [DW-1:0]                diff_reg, diff_next;
    logic [DW-1:0]                rem_reg, rem_next;
    logic [kvi_pkg::FRAC_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [kvi_pkg::BLEND_W-1:0]  factor_reg, factor_next;

    logic                         dir;
    logic [DW:0]                  rem_sh;
    logic                         ge;

    always_comb
    begin
        dir    = req.t1 < req.t0;
        rem_sh = {rem_reg, 1'b0};
        ge     = rem_sh >= {1'b0, diff_reg};

        state_next  = state_reg;
        mid_next    = mid_reg;
        diff_next   = diff_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        factor_next = factor_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (req.start)
                begin
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                // Keys out of order swap the roles of both ends.
                if (dir)
                begin
                    mid_next  = $signed({1'b0, req.t0}) - $signed({1'b0, req.q});
                    diff_next = req.t0 - req.t1;
                end
                else
                begin
                    mid_next  = $signed({1'b0, req.q}) - $signed({1'b0, req.t0});
                    diff_next = req.t1 - req.t0;
                end
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (diff_reg == '0 || mid_reg[DW] || mid_reg == '0)
                begin
                    factor_next = kvi_pkg::BLEND_ZERO;
                    done_next   = 1'b1;
                    state_next  = B_IDLE;
                end
                else if (mid_reg[DW-1:0] >= diff_reg)
                begin
                    factor_next = kvi_pkg::BLEND_ONE;
                    done_next   = 1'b1;
                    state_next  = B_IDLE;
                end
                else
                begin
                    rem_next   = mid_reg[DW-1:0];
                    quo_next   = '0;
                    cnt_next   = CNT_W'(kvi_pkg::FRAC_W);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next = ge ? DW'(rem_sh - {1'b0, diff_reg}) : rem_sh[DW-1:0];
                quo_next = {quo_reg[kvi_pkg::FRAC_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    factor_next = {1'b0, quo_next};
                    done_next   = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg    <= mid_next;
        diff_reg   <= diff_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        factor_reg <= factor_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.factor = factor_reg;

endmodule

### rtl/kvi_mix.sv
// Linear blend unit: one shared multiplier walks the three vector components.
module kvi_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  kvi_pkg::mix_req_t req,
    output kvi_pkg::mix_rsp_t rsp
);

    localparam int DW = kvi_pkg::DATA_W;
    localparam int PW = kvi_pkg::PROD_W;
    localparam int FW = kvi_pkg::FRAC_W;

    logic                     busy_reg, busy_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     pvalid_reg, pvalid_next;
    logic [1:0]               pcnt_reg, pcnt_next;
    logic                     done_reg, done_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    kvi_pkg::vec_t            res_reg;

    logic signed [DW:0]       dsub;
    logic signed [kvi_pkg::BLEND_W:0] fac_s;

    always_comb
    begin
        dsub  = $signed({req.b[cnt_reg][DW-1], req.b[cnt_reg]})
              - $signed({req.a[cnt_reg][DW-1], req.a[cnt_reg]});
        fac_s = $signed({1'b0, req.factor});
        prod_next = dsub * fac_s + kvi_pkg::MIX_HALF;

        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        pvalid_next = 1'b0;
        pcnt_next   = pcnt_reg;
        done_next   = pvalid_reg && (pcnt_reg == 2'd2);

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
        else if (busy_reg)
        begin
            pvalid_next = 1'b1;
            pcnt_next   = cnt_reg;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            pvalid_reg <= 1'b0;
            pcnt_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            pvalid_reg <= pvalid_next;
            pcnt_reg   <= pcnt_next;
            done_reg   <= done_next;
        end
    end

    // A zero factor returns the lower key unchanged, whatever the upper key holds.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (pvalid_reg)
        begin
            if (req.factor == kvi_pkg::BLEND_ZERO)
            begin
                res_reg[pcnt_reg] <= req.a[pcnt_reg];
            end
            else
            begin
                res_reg[pcnt_reg] <= req.a[pcnt_reg] + prod_reg[FW+DW-1:FW];
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.v    = res_reg;

endmodule

### sim/kvi_result_checker.sv
// Checker that predicts every interpolated sample and compares it with the block's results.
`timescale 1ns / 100ps
module kvi_result_checker #(
    parameter int KEY_SLOTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kvi_pkg::COUNT_W-1:0]        cfg_wdata,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               func,
    input  logic [kvi_pkg::SLOT_W-1:0]         key_slot,
    input  logic [kvi_pkg::DATA_W-1:0]         key_time,
    input  logic signed [kvi_pkg::DATA_W-1:0]  key_x,
    input  logic signed [kvi_pkg::DATA_W-1:0]  key_y,
    input  logic signed [kvi_pkg::DATA_W-1:0]  key_z,
    input  logic [kvi_pkg::DATA_W-1:0]         query_time,
    input  logic                               res_valid,
    input  logic                               res_ready,
    input  logic signed [kvi_pkg::DATA_W-1:0]  out_x,
    input  logic signed [kvi_pkg::DATA_W-1:0]  out_y,
    input  logic signed [kvi_pkg::DATA_W-1:0]  out_z,
    input  logic [kvi_pkg::SLOT_W-1:0]         segment,
    input  logic [kvi_pkg::BLEND_W-1:0]        blend,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 results_checked
);

    localparam longint Q16_ONE = 65536;
    localparam longint Q16_HALF = 32768;

    typedef struct packed {
        logic [kvi_pkg::DATA_W-1:0]  x;
        logic [kvi_pkg::DATA_W-1:0]  y;
        logic [kvi_pkg::DATA_W-1:0]  z;
        logic [kvi_pkg::SLOT_W-1:0]  seg;
        logic [kvi_pkg::BLEND_W-1:0] factor;
    } track_sample_t;

    logic [kvi_pkg::DATA_W-1:0]  time_store [KEY_SLOTS];
    kvi_pkg::vec_t               vec_store [KEY_SLOTS];
    logic [kvi_pkg::COUNT_W-1:0] count_reg;
    track_sample_t               predicted_samples [$];
    int                          faults;
    int                          checked;

    function automatic logic [kvi_pkg::BLEND_W-1:0] blend_of(
        logic [kvi_pkg::DATA_W-1:0] t0,
        logic [kvi_pkg::DATA_W-1:0] t1,
        logic [kvi_pkg::DATA_W-1:0] q);
        longint mid;
        longint span;
        mid = longint'({32'd0, q}) - longint'({32'd0, t0});
        span = longint'({32'd0, t1}) - longint'({32'd0, t0});
        if (span == 0)
            return kvi_pkg::BLEND_ZERO;
        if (span < 0)
        begin
            span = -span;
            mid = -mid;
        end
        if (mid <= 0)
            return kvi_pkg::BLEND_ZERO;
        if (mid >= span)
            return kvi_pkg::BLEND_ONE;
        return kvi_pkg::BLEND_W'((mid * Q16_ONE) / span);
    endfunction

    function automatic logic [kvi_pkg::DATA_W-1:0] mix_of(
        logic signed [kvi_pkg::DATA_W-1:0] a,
        logic signed [kvi_pkg::DATA_W-1:0] b,
        logic [kvi_pkg::BLEND_W-1:0] f);
        longint delta;
        delta = (longint'(b) - longint'(a)) * longint'({47'd0, f}) + Q16_HALF;
        return kvi_pkg::DATA_W'(longint'(a) + (delta >>> 16));
    endfunction

    function automatic track_sample_t interpolate_track(logic [kvi_pkg::DATA_W-1:0] q);
        track_sample_t r;
        int n;
        int seg;
        logic [kvi_pkg::BLEND_W-1:0] f;
        if (count_reg == 0)
            n = 1;
        else if (count_reg > KEY_SLOTS)
            n = KEY_SLOTS;
        else
            n = int'(count_reg);
        if (n == 1)
        begin
            seg = 0;
            f = kvi_pkg::BLEND_ZERO;
            r.x = vec_store[0][0];
            r.y = vec_store[0][1];
            r.z = vec_store[0][2];
        end
        else
        begin
            seg = n - 2;
            for (int i = n - 2; i >= 0; i--)
                if (q < time_store[i + 1])
                    seg = i;
            f = blend_of(time_store[seg], time_store[seg + 1], q);
            r.x = mix_of(vec_store[seg][0], vec_store[seg + 1][0], f);
            r.y = mix_of(vec_store[seg][1], vec_store[seg + 1][1], f);
            r.z = mix_of(vec_store[seg][2], vec_store[seg + 1][2], f);
        end
        r.seg = kvi_pkg::SLOT_W'(seg);
        r.factor = f;
        return r;
    endfunction

    task automatic compare_field(string name, logic [kvi_pkg::DATA_W-1:0] want,
                                 logic [kvi_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            faults++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        track_sample_t want;
        if (!rst_n)
        begin
            count_reg = kvi_pkg::COUNT_RESET;
            predicted_samples.delete();
        end
        else
        begin
            if (cfg_we)
                count_reg = cfg_wdata;
            if (res_valid && res_ready)
            begin
                if (predicted_samples.size() == 0)
                begin
                    faults++;
                    $display("%0t: result with no query outstanding, actual x=%h y=%h z=%h",
                             $time, out_x, out_y, out_z);
                end
                else
                begin
                    want = predicted_samples.pop_front();
                    checked++;
                    compare_field("out_x", want.x, out_x);
                    compare_field("out_y", want.y, out_y);
                    compare_field("out_z", want.z, out_z);
                    compare_field("segment", kvi_pkg::DATA_W'(want.seg),
                                  kvi_pkg::DATA_W'(segment));
                    compare_field("blend", kvi_pkg::DATA_W'(want.factor),
                                  kvi_pkg::DATA_W'(blend));
                end
            end
            if (req_valid && req_ready)
            begin
                if (func == kvi_pkg::FUNC_WRITE)
                begin
                    if (key_slot < KEY_SLOTS)
                    begin
                        time_store[key_slot] = key_time;
                        vec_store[key_slot] = {key_z, key_y, key_x};
                    end
                end
                else
                    predicted_samples.insert(predicted_samples.size(),
                                             interpolate_track(query_time));
            end
        end
        mismatches <= faults;
        pending <= predicted_samples.size();
        results_checked <= checked;
    end

endmodule

### sim/keyframe_vector_interpolator_core_test.sv
// Testbench top: drives key writes and queries into the interpolator and gives the verdict.
`timescale 1ns / 100ps
module keyframe_vector_interpolator_core_test;

    localparam int KEY_SLOTS = 64;
    localparam int ITEM_TARGET = 1900;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES = 2000;
    localparam int HOLD_AFTER = 700;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [kvi_pkg::COUNT_W-1:0]        cfg_wdata = '0;
    logic                               req_valid = 1'b0;
    logic                               req_ready;
    logic                               func = kvi_pkg::FUNC_WRITE;
    logic [kvi_pkg::SLOT_W-1:0]         key_slot = '0;
    logic [kvi_pkg::DATA_W-1:0]         key_time = '0;
    logic signed [kvi_pkg::DATA_W-1:0]  key_x = '0;
    logic signed [kvi_pkg::DATA_W-1:0]  key_y = '0;
    logic signed [kvi_pkg::DATA_W-1:0]  key_z = '0;
    logic [kvi_pkg::DATA_W-1:0]         query_time = '0;
    logic                               res_valid;
    logic                               res_ready = 1'b0;
    logic signed [kvi_pkg::DATA_W-1:0]  out_x;
    logic signed [kvi_pkg::DATA_W-1:0]  out_y;
    logic signed [kvi_pkg::DATA_W-1:0]  out_z;
    logic [kvi_pkg::SLOT_W-1:0]         segment;
    logic [kvi_pkg::BLEND_W-1:0]        blend;

    int mismatches;
    int pending;
    int results_checked;
    int request_total;
    int query_total;
    int write_total;
    int setting_total;
    int live_keys;
    int phase_len;
    bit hold_due;
    bit hold_done;
    bit [KEY_SLOTS-1:0] slot_written;
    logic [kvi_pkg::DATA_W-1:0] time_shadow [KEY_SLOTS];

    keyframe_vector_interpolator_core #(
        .MAX_KEYS(KEY_SLOTS)
    ) dut (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .req_valid, .req_ready,
        .func, .key_slot, .key_time, .key_x, .key_y, .key_z, .query_time,
        .res_valid, .res_ready, .out_x, .out_y, .out_z, .segment, .blend
    );

    kvi_result_checker #(
        .KEY_SLOTS(KEY_SLOTS)
    ) results_check (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .req_valid, .req_ready,
        .func, .key_slot, .key_time, .key_x, .key_y, .key_z, .query_time,
        .res_valid, .res_ready, .out_x, .out_y, .out_z, .segment, .blend,
        .mismatches, .pending, .results_checked
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [kvi_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [kvi_pkg::COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return kvi_pkg::COUNT_W'(0);
        if (r < 8)
            return kvi_pkg::COUNT_W'(127);
        if (r < 12)
            return kvi_pkg::COUNT_W'(64);
        if (r < 15)
            return kvi_pkg::COUNT_W'(1);
        if (r < 20)
            return kvi_pkg::COUNT_W'($urandom_range(65, 126));
        if (r < 35)
            return kvi_pkg::COUNT_W'($urandom_range(13, 63));
        return kvi_pkg::COUNT_W'($urandom_range(2, 12));
    endfunction

    function automatic logic [kvi_pkg::DATA_W-1:0] pick_query_time();
        logic [kvi_pkg::DATA_W-1:0] lo;
        logic [kvi_pkg::DATA_W-1:0] hi;
        int r;
        lo = time_shadow[0];
        hi = time_shadow[live_keys - 1];
        r = $urandom_range(0, 99);
        if (r < 10)
            return time_shadow[$urandom_range(0, live_keys - 1)];
        if (r < 25)
            return $urandom;
        if (r < 32)
            return (lo > 1000) ? lo - $urandom_range(1, 1000) : 32'h0;
        if (r < 39)
            return (hi < 32'hFFFF_FC00) ? hi + $urandom_range(1, 1000) : 32'hFFFF_FFFF;
        if (hi > lo)
            return lo + $urandom_range(0, hi - lo);
        return lo;
    endfunction

    task automatic send_request(logic f, logic [kvi_pkg::SLOT_W-1:0] slot,
                                logic [kvi_pkg::DATA_W-1:0] t,
                                logic [kvi_pkg::DATA_W-1:0] x,
                                logic [kvi_pkg::DATA_W-1:0] y,
                                logic [kvi_pkg::DATA_W-1:0] z,
                                logic [kvi_pkg::DATA_W-1:0] qt);
        int gap;
        gap = pick_gap();
        req_valid <= 1'b1;
        func <= f;
        key_slot <= slot;
        key_time <= t;
        key_x <= x;
        key_y <= y;
        key_z <= z;
        query_time <= qt;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        request_total++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_key(logic [kvi_pkg::SLOT_W-1:0] slot,
                             logic [kvi_pkg::DATA_W-1:0] t,
                             logic [kvi_pkg::DATA_W-1:0] x,
                             logic [kvi_pkg::DATA_W-1:0] y,
                             logic [kvi_pkg::DATA_W-1:0] z);
        send_request(kvi_pkg::FUNC_WRITE, slot, t, x, y, z, $urandom);
        slot_written[slot] = 1'b1;
        time_shadow[slot] = t;
        write_total++;
    endtask

    // Every slot that a query may walk over is written before the query goes out.
    task automatic query_at(logic [kvi_pkg::DATA_W-1:0] q);
        for (int s = 0; s < live_keys; s++)
            if (!slot_written[s])
                write_key(kvi_pkg::SLOT_W'(s), $urandom, pick_word(), pick_word(),
                          pick_word());
        send_request(kvi_pkg::FUNC_QUERY, kvi_pkg::SLOT_W'($urandom), $urandom, $urandom,
                     $urandom, $urandom, q);
        query_total++;
    endtask

    task automatic write_ordered_track();
        logic [kvi_pkg::DATA_W-1:0] t;
        logic [kvi_pkg::DATA_W-1:0] stride;
        t = $urandom >> $urandom_range(0, 31);
        for (int s = 0; s < live_keys; s++)
        begin
            write_key(kvi_pkg::SLOT_W'(s), t, pick_word(), pick_word(), pick_word());
            if ($urandom_range(0, 9) == 0)
                stride = '0;
            else
                stride = $urandom_range(1, 1 << $urandom_range(0, 24));
            t = (t > 32'hFFFF_FFFF - stride) ? 32'hFFFF_FFFF : t + stride;
        end
    endtask

    // A stray key write: either a fresh time anywhere, or a new vector at the old time.
    task automatic key_slot_pick();
        logic [kvi_pkg::SLOT_W-1:0] slot;
        slot = kvi_pkg::SLOT_W'($urandom_range(0, KEY_SLOTS - 1));
        if ($urandom_range(0, 1) == 0)
            write_key(slot, $urandom, pick_word(), pick_word(), pick_word());
        else
            write_key(slot, time_shadow[slot], pick_word(), pick_word(), pick_word());
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(logic [kvi_pkg::COUNT_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (v == 0)
            live_keys = 1;
        else if (v > KEY_SLOTS)
            live_keys = KEY_SLOTS;
        else
            live_keys = int'(v);
        setting_total++;
    endtask

    initial
    begin
        for (int s = 0; s < KEY_SLOTS; s++)
            time_shadow[s] = '0;
        live_keys = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_key(kvi_pkg::SLOT_W'(0), 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0001);
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
        drain();
        set_count(kvi_pkg::COUNT_W'(0));
        query_at(32'h1234_5678);
        drain();
        set_count(kvi_pkg::COUNT_W'(2));
        write_key(kvi_pkg::SLOT_W'(0), 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_0000);
        write_key(kvi_pkg::SLOT_W'(1), 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0001);
        query_at(32'h0000_0000);
        query_at(32'h0001_0000);
        query_at(32'h0000_0001);
        query_at(32'h0002_0000);
        query_at(32'hFFFF_FFFF);
        // Keys out of order: the query sits half way between them, so halves are rounded.
        write_key(kvi_pkg::SLOT_W'(0), 32'h0003_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0000);
        write_key(kvi_pkg::SLOT_W'(1), 32'h0001_0000, 32'h0000_0001, 32'h0000_0000,
                  32'hFFFF_FFFF);
        query_at(32'h0002_0000);
        query_at(32'h0000_0000);
        write_key(kvi_pkg::SLOT_W'(1), 32'h0003_0000, 32'h0000_0005, 32'h0000_0006,
                  32'h0000_0007);
        query_at(32'h0003_0000);

        while (request_total < ITEM_TARGET)
        begin
            drain();
            set_count(pick_count());
            if ($urandom_range(0, 9) < 7)
                write_ordered_track();
            phase_len = $urandom_range(20, 80);
            repeat (phase_len)
            begin
                if (request_total >= HOLD_AFTER)
                    hold_due = 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    key_slot_pick();
                end
                else
                    query_at(pick_query_time());
            end
        end
        drain();

        $display("Run covered %0d requests: %0d queries and %0d key writes,",
                 request_total, query_total, write_total);
        $display("over %0d key-count settings; %0d results were compared field by field.",
                 setting_total, results_checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int span;
        int r;
        @(posedge clk);
        forever
        begin
            if (hold_due && !hold_done)
            begin
                hold_done = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    res_ready <= 1'b1;
                    span = $urandom_range(1, 30);
                end
                else
                begin
                    res_ready <= 1'b0;
                    if (r < 80)
                        span = $urandom_range(1, 3);
                    else if (r < 95)
                        span = $urandom_range(4, 15);
                    else
                        span = $urandom_range(30, 200);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
